>>> rtl/cpu65_pkg.sv
// Shared types, operation codes and helpers for the 6502 execute unit.
// Depends on nothing; every other file in rtl/ uses it by scoped names.
package cpu65_pkg;

    // Operation codes carried by the op field.
    localparam logic [4:0] OP_ADC        = 5'd0;
    localparam logic [4:0] OP_SBC        = 5'd1;
    localparam logic [4:0] OP_AND        = 5'd2;
    localparam logic [4:0] OP_ORA        = 5'd3;
    localparam logic [4:0] OP_EOR        = 5'd4;
    localparam logic [4:0] OP_BIT        = 5'd5;
    localparam logic [4:0] OP_CMP        = 5'd6;
    localparam logic [4:0] OP_ASL        = 5'd7;
    localparam logic [4:0] OP_LSR        = 5'd8;
    localparam logic [4:0] OP_ROL        = 5'd9;
    localparam logic [4:0] OP_ROR        = 5'd10;
    localparam logic [4:0] OP_INC        = 5'd11;
    localparam logic [4:0] OP_DEC        = 5'd12;
    localparam logic [4:0] OP_LOAD       = 5'd13;
    localparam logic [4:0] OP_STORE      = 5'd14;
    localparam logic [4:0] OP_TRANSFER   = 5'd15;
    localparam logic [4:0] OP_FLAGWRITE  = 5'd16;
    localparam logic [4:0] OP_PULLSTATUS = 5'd17;
    localparam logic [4:0] OP_PUSHSTATUS = 5'd18;
    localparam logic [4:0] OP_BRANCHTEST = 5'd19;

    // Register select codes.
    localparam logic [1:0] SEL_A   = 2'd0;
    localparam logic [1:0] SEL_X   = 2'd1;
    localparam logic [1:0] SEL_Y   = 2'd2;
    localparam logic [1:0] SEL_MEM = 2'd3;

    // Transfer kinds.
    localparam logic [2:0] XFER_TAX = 3'd0;
    localparam logic [2:0] XFER_TXA = 3'd1;
    localparam logic [2:0] XFER_TAY = 3'd2;
    localparam logic [2:0] XFER_TYA = 3'd3;
    localparam logic [2:0] XFER_TSX = 3'd4;
    localparam logic [2:0] XFER_TXS = 3'd5;

    // Flag indexes for flag writes.
    localparam logic [2:0] FLAG_C = 3'd0;
    localparam logic [2:0] FLAG_I = 3'd1;
    localparam logic [2:0] FLAG_V = 3'd2;
    localparam logic [2:0] FLAG_D = 3'd3;

    // Branch condition groups, aux[2:1]; aux[0] selects "flag set".
    localparam logic [1:0] BR_CARRY    = 2'd0;
    localparam logic [1:0] BR_ZERO     = 2'd1;
    localparam logic [1:0] BR_OVERFLOW = 2'd2;
    localparam logic [1:0] BR_NEGATIVE = 2'd3;

    localparam logic [7:0] STATUS_ONE_MASK = 8'h20;
    localparam logic [7:0] STATUS_B_MASK   = 8'h10;
    localparam logic [7:0] SP_RESET        = 8'hFD;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] reg_sel;
        logic [7:0] operand;
        logic [2:0] aux;
        logic       bit_value;
    } item_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic       n;
        logic       v;
        logic       d;
        logic       i;
        logic       z;
        logic       c;
    } arch_state_t;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] status;
        logic       branch_taken;
    } exec_out_t;

    localparam arch_state_t ARCH_RESET = '{
        a: 8'h00, x: 8'h00, y: 8'h00, s: SP_RESET,
        n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0
    };

    // Packs the flags as N V 1 B D I Z C with B clear.
    function automatic logic [7:0] pack_status(input arch_state_t st);
        return {st.n, st.v, 1'b1, 1'b0, st.d, st.i, st.z, st.c};
    endfunction

endpackage

>>> rtl/cpu6502_execute_unit.sv
// Top level of the 6502 execute unit (binary ADC/SBC, D flag stored only).
// Depends on cpu65_pkg and the modules cpu65_input_stage, cpu65_arch_regs,
// cpu65_exec and cpu65_output_stage.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_op, s_reg_sel, s_operand, s_aux,
//           |           |                    | s_bit_value
//  m_       | out       | m_valid / m_ready  | m_result, m_status, m_branch_taken
//
// An accepted item waits in the input register and is loaded into the result register
// when it executes; A, X, Y, S and the flags update at that same edge, so the following
// item sees them. One item is accepted every cycle while m_ready stays high. Reset
// (aresetn low, sampled on aclk) empties both registers, clears A, X, Y and all flags
// but I, and sets S to 0xFD. A result held by low m_ready keeps the next item in the
// input register, and s_ready drops once that register is full too; nothing is dropped or repeated.
module cpu6502_execute_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [4:0] s_op,
    input  logic [1:0] s_reg_sel,
    input  logic [7:0] s_operand,
    input  logic [2:0] s_aux,
    input  logic       s_bit_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result,
    output logic [7:0] m_status,
    output logic       m_branch_taken
);

    cpu65_pkg::item_t       item_in;
    cpu65_pkg::item_t       item;
    cpu65_pkg::arch_state_t state;
    cpu65_pkg::arch_state_t state_next;
    cpu65_pkg::exec_out_t   exec_out;
    cpu65_pkg::exec_out_t   out_data;
    logic                   out_busy;
    logic                   advance;

    assign item_in = '{
        op:        s_op,
        reg_sel:   s_reg_sel,
        operand:   s_operand,
        aux:       s_aux,
        bit_value: s_bit_value
    };

    // The held item moves on whenever the result register is free or draining.
    cpu65_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .item_in    (item_in),
        .advance_ok (~out_busy),
        .advance    (advance),
        .item_out   (item)
    );

    // Architectural registers commit exactly when an item is executed.
    cpu65_arch_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .state_next (state_next),
        .state      (state)
    );

    cpu65_exec u_exec (
        .item       (item),
        .state      (state),
        .state_next (state_next),
        .out        (exec_out)
    );

    cpu65_output_stage u_output (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .data_in  (exec_out),
        .busy     (out_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .data_out (out_data)
    );

    assign m_result       = out_data.result;
    assign m_status       = out_data.status;
    assign m_branch_taken = out_data.branch_taken;

    // An executed item always shows up as a result in the next cycle.
    a_exec_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("executed item did not reach the result register");

    // Registers and flags change only when an item is executed.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state))
        else $error("architectural state changed without an executed item");

    // The B bit appears only on a status push, whose result is that status.
    a_push_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status[4] |-> m_result == m_status)
        else $error("B bit set without matching pushed status byte");

    // A taken branch test produces no write-back byte.
    a_branch_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_branch_taken |-> m_result == 8'h00 && !m_status[4])
        else $error("taken branch carries a result byte");

endmodule

>>> rtl/cpu65_arch_regs.sv
// Architectural register file of the execute unit: A, X, Y, S and flags.
// Depends on cpu65_pkg for the state type and reset values.
module cpu65_arch_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  update,
    input  cpu65_pkg::arch_state_t state_next,
    output cpu65_pkg::arch_state_t state
);

    cpu65_pkg::arch_state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpu65_pkg::ARCH_RESET;
        end else if (update) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

>>> rtl/cpu65_exec.sv
// Combinational execute logic: one operation against the current registers.
// Depends on cpu65_pkg for item, state and result types and operation codes.
module cpu65_exec (
    input  cpu65_pkg::item_t       item,
    input  cpu65_pkg::arch_state_t state,
    output cpu65_pkg::arch_state_t state_next,
    output cpu65_pkg::exec_out_t   out
);

    logic [7:0] sel_value;
    logic [7:0] add_in;
    logic [8:0] add_sum;
    logic [8:0] cmp_diff;
    logic       branch_flag;

    always_comb begin
        case (item.reg_sel)
            cpu65_pkg::SEL_A: sel_value = state.a;
            cpu65_pkg::SEL_X: sel_value = state.x;
            cpu65_pkg::SEL_Y: sel_value = state.y;
            default:          sel_value = item.operand;
        endcase
    end

    // SBC is ADC of the inverted operand; decimal mode does not exist here.
    assign add_in   = (item.op == cpu65_pkg::OP_SBC) ? ~item.operand : item.operand;
    assign add_sum  = {1'b0, state.a} + {1'b0, add_in} + {8'h00, state.c};
    assign cmp_diff = {1'b0, sel_value} - {1'b0, item.operand};

    always_comb begin
        case (item.aux[2:1])
            cpu65_pkg::BR_CARRY:    branch_flag = state.c;
            cpu65_pkg::BR_ZERO:     branch_flag = state.z;
            cpu65_pkg::BR_OVERFLOW: branch_flag = state.v;
            default:                branch_flag = state.n;
        endcase
    end

    always_comb begin
        logic [7:0] value;
        logic       pushed;

        state_next       = state;
        value            = 8'h00;
        pushed           = 1'b0;
        out.branch_taken = 1'b0;

        unique case (item.op) inside
            cpu65_pkg::OP_ADC, cpu65_pkg::OP_SBC: begin
                value        = add_sum[7:0];
                state_next.a = value;
                state_next.c = add_sum[8];
                state_next.v = ~(state.a[7] ^ add_in[7]) & (state.a[7] ^ add_sum[7]);
                state_next.z = (value == 8'h00);
                state_next.n = value[7];
            end
            cpu65_pkg::OP_AND, cpu65_pkg::OP_ORA, cpu65_pkg::OP_EOR: begin
                case (item.op)
                    cpu65_pkg::OP_AND: value = state.a & item.operand;
                    cpu65_pkg::OP_ORA: value = state.a | item.operand;
                    default:           value = state.a ^ item.operand;
                endcase
                state_next.a = value;
                state_next.z = (value == 8'h00);
                state_next.n = value[7];
            end
            cpu65_pkg::OP_BIT: begin
                state_next.z = ((state.a & item.operand) == 8'h00);
                state_next.v = item.operand[6];
                state_next.n = item.operand[7];
            end
            cpu65_pkg::OP_CMP: begin
                state_next.c = ~cmp_diff[8];
                state_next.z = (cmp_diff[7:0] == 8'h00);
                state_next.n = cmp_diff[7];
            end
            cpu65_pkg::OP_ASL, cpu65_pkg::OP_LSR, cpu65_pkg::OP_ROL,
            cpu65_pkg::OP_ROR, cpu65_pkg::OP_INC, cpu65_pkg::OP_DEC: begin
                case (item.op)
                    cpu65_pkg::OP_ASL: begin
                        value        = {sel_value[6:0], 1'b0};
                        state_next.c = sel_value[7];
                    end
                    cpu65_pkg::OP_LSR: begin
                        value        = {1'b0, sel_value[7:1]};
                        state_next.c = sel_value[0];
                    end
                    cpu65_pkg::OP_ROL: begin
                        value        = {sel_value[6:0], state.c};
                        state_next.c = sel_value[7];
                    end
                    cpu65_pkg::OP_ROR: begin
                        value        = {state.c, sel_value[7:1]};
                        state_next.c = sel_value[0];
                    end
                    cpu65_pkg::OP_INC: value = sel_value + 8'd1;
                    default:           value = sel_value - 8'd1;
                endcase
                state_next.z = (value == 8'h00);
                state_next.n = value[7];
                case (item.reg_sel)
                    cpu65_pkg::SEL_A: state_next.a = value;
                    cpu65_pkg::SEL_X: state_next.x = value;
                    cpu65_pkg::SEL_Y: state_next.y = value;
                    default: ;
                endcase
            end
            cpu65_pkg::OP_LOAD: begin
                value        = item.operand;
                state_next.z = (value == 8'h00);
                state_next.n = value[7];
                case (item.reg_sel)
                    cpu65_pkg::SEL_A: state_next.a = value;
                    cpu65_pkg::SEL_X: state_next.x = value;
                    cpu65_pkg::SEL_Y: state_next.y = value;
                    default: ;
                endcase
            end
            cpu65_pkg::OP_STORE: begin
                value = sel_value;
            end
            cpu65_pkg::OP_TRANSFER: begin
                case (item.aux)
                    cpu65_pkg::XFER_TAX: begin
                        value        = state.a;
                        state_next.x = value;
                    end
                    cpu65_pkg::XFER_TXA: begin
                        value        = state.x;
                        state_next.a = value;
                    end
                    cpu65_pkg::XFER_TAY: begin
                        value        = state.a;
                        state_next.y = value;
                    end
                    cpu65_pkg::XFER_TYA: begin
                        value        = state.y;
                        state_next.a = value;
                    end
                    cpu65_pkg::XFER_TSX: begin
                        value        = state.s;
                        state_next.x = value;
                    end
                    cpu65_pkg::XFER_TXS: begin
                        value        = state.x;
                        state_next.s = value;
                    end
                    default: ;
                endcase
                // Every transfer but TXS sets N and Z; unused kinds do nothing.
                if (item.aux <= cpu65_pkg::XFER_TSX) begin
                    state_next.z = (value == 8'h00);
                    state_next.n = value[7];
                end
            end
            cpu65_pkg::OP_FLAGWRITE: begin
                case (item.aux)
                    cpu65_pkg::FLAG_C: state_next.c = item.bit_value;
                    cpu65_pkg::FLAG_I: state_next.i = item.bit_value;
                    cpu65_pkg::FLAG_V: state_next.v = item.bit_value;
                    cpu65_pkg::FLAG_D: state_next.d = item.bit_value;
                    default: ;
                endcase
            end
            cpu65_pkg::OP_PULLSTATUS: begin
                state_next.s = state.s + 8'd1;
                state_next.n = item.operand[7];
                state_next.v = item.operand[6];
                state_next.d = item.operand[3];
                state_next.i = item.operand[2];
                state_next.z = item.operand[1];
                state_next.c = item.operand[0];
            end
            cpu65_pkg::OP_PUSHSTATUS: begin
                value        = cpu65_pkg::pack_status(state) | cpu65_pkg::STATUS_B_MASK;
                state_next.s = state.s - 8'd1;
                pushed       = 1'b1;
            end
            cpu65_pkg::OP_BRANCHTEST: begin
                out.branch_taken = item.aux[0] ? branch_flag : ~branch_flag;
            end
            default: ;
        endcase

        out.result = value;
        out.status = cpu65_pkg::pack_status(state_next) |
                     (pushed ? cpu65_pkg::STATUS_B_MASK : 8'h00);
    end

endmodule

>>> rtl/cpu65_output_stage.sv
// Result register of the execute unit with its valid/ready handshake.
// Depends on cpu65_pkg for the result type.
module cpu65_output_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  cpu65_pkg::exec_out_t data_in,
    output logic                 busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cpu65_pkg::exec_out_t data_out
);

    logic                 valid_reg;
    cpu65_pkg::exec_out_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_in;
        end
    end

    // The register can take a new result when empty or drained this cycle.
    assign busy     = valid_reg & ~m_ready;
    assign m_valid  = valid_reg;
    assign data_out = data_reg;

endmodule

>>> rtl/cpu65_execute_unit_top_placeholder.sv
// Input register of the execute unit: holds one accepted item for execution.
// Depends on cpu65_pkg for the item type.
module cpu65_input_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cpu65_pkg::item_t item_in,
    input  logic             advance_ok,
    output logic             advance,
    output cpu65_pkg::item_t item_out
);

    logic             valid_reg;
    cpu65_pkg::item_t item_reg;

    assign advance = valid_reg & advance_ok;
    assign s_ready = ~valid_reg | advance_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_in;
        end
    end

    assign item_out = item_reg;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the 6502 execute unit (cpu6502_execute_unit).
// Depends on cpu65_pkg for the operation, select, transfer, flag and branch codes
// and on the RTL of the unit; it keeps its own model of the registers and flags.
module tb_top;
    import cpu65_pkg::*;

    // Codes that the package does not name but that the stimulus must reach.
    localparam logic [4:0] OP_UNUSED  = 5'd31;
    localparam logic [2:0] AUX_NONE   = 3'd0;
    localparam logic [2:0] XFER_NONE  = 3'd7;
    localparam logic [2:0] FLAG_NONE  = 3'd6;
    localparam int         HOLD_LEN   = 60;
    localparam int         DRAIN_GAP  = 8;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [4:0] s_op = '0;
    logic [1:0] s_reg_sel = '0;
    logic [7:0] s_operand = '0;
    logic [2:0] s_aux = '0;
    logic       s_bit_value = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_result;
    logic [7:0] m_status;
    logic       m_branch_taken;

    // Architectural state as the testbench believes it to be after every
    // accepted item, and the outcomes that the unit still owes us, oldest first.
    arch_state_t cpu_regs;
    exec_out_t   expected_outcomes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req_id = 0;
    int hold_done_id = 0;
    int hold_cnt = 0;
    int items_sent = 0;
    int results_checked = 0;
    int fail_count = 0;

    cpu6502_execute_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_reg_sel      (s_reg_sel),
        .s_operand      (s_operand),
        .s_aux          (s_aux),
        .s_bit_value    (s_bit_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result       (m_result),
        .m_status       (m_status),
        .m_branch_taken (m_branch_taken)
    );

    always #10 aclk = ~aclk;

    // Writes a value back to the register that reg_sel names. The memory
    // select has no register behind it, so the value only leaves as result.
    function automatic void write_back(input logic [1:0] sel, input logic [7:0] val);
        case (sel)
            SEL_A:   cpu_regs.a = val;
            SEL_X:   cpu_regs.x = val;
            SEL_Y:   cpu_regs.y = val;
            default: ;
        endcase
    endfunction

    // Applies one item to cpu_regs and returns the outcome the unit must show.
    function automatic exec_out_t execute_op(input item_t it);
        exec_out_t  outc;
        logic [8:0] sum;
        logic [7:0] addend;
        logic [7:0] src;
        logic [7:0] val;
        logic [7:0] diff;
        logic       old_c;
        logic       flag;
        logic       pushed;
        outc = '0;
        pushed = 1'b0;
        case (it.reg_sel)
            SEL_A:   src = cpu_regs.a;
            SEL_X:   src = cpu_regs.x;
            SEL_Y:   src = cpu_regs.y;
            default: src = it.operand;
        endcase
        case (it.op)
            OP_ADC, OP_SBC: begin
                // Subtraction is addition of the inverted operand; no decimal mode.
                addend = (it.op == OP_SBC) ? ~it.operand : it.operand;
                sum = {1'b0, cpu_regs.a} + {1'b0, addend} + {8'd0, cpu_regs.c};
                cpu_regs.v = ~(cpu_regs.a[7] ^ addend[7]) & (cpu_regs.a[7] ^ sum[7]);
                cpu_regs.c = sum[8];
                cpu_regs.a = sum[7:0];
                {cpu_regs.n, cpu_regs.z} = {sum[7], sum[7:0] == 8'h00};
                outc.result = cpu_regs.a;
            end
            OP_AND, OP_ORA, OP_EOR: begin
                if (it.op == OP_AND) cpu_regs.a = cpu_regs.a & it.operand;
                else if (it.op == OP_ORA) cpu_regs.a = cpu_regs.a | it.operand;
                else cpu_regs.a = cpu_regs.a ^ it.operand;
                {cpu_regs.n, cpu_regs.z} = {cpu_regs.a[7], cpu_regs.a == 8'h00};
                outc.result = cpu_regs.a;
            end
            OP_BIT: begin
                cpu_regs.z = (cpu_regs.a & it.operand) == 8'h00;
                cpu_regs.v = it.operand[6];
                cpu_regs.n = it.operand[7];
            end
            OP_CMP: begin
                diff = src - it.operand;
                cpu_regs.c = src >= it.operand;
                cpu_regs.z = src == it.operand;
                cpu_regs.n = diff[7];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
                old_c = cpu_regs.c;
                val = src;
                case (it.op)
                    OP_ASL: begin cpu_regs.c = val[7]; val = {val[6:0], 1'b0}; end
                    OP_LSR: begin cpu_regs.c = val[0]; val = {1'b0, val[7:1]}; end
                    OP_ROL: begin cpu_regs.c = val[7]; val = {val[6:0], old_c}; end
                    OP_ROR: begin cpu_regs.c = val[0]; val = {old_c, val[7:1]}; end
                    OP_INC: val = val + 8'd1;
                    default: val = val - 8'd1;
                endcase
                {cpu_regs.n, cpu_regs.z} = {val[7], val == 8'h00};
                write_back(it.reg_sel, val);
                outc.result = val;
            end
            OP_LOAD: begin
                write_back(it.reg_sel, it.operand);
                {cpu_regs.n, cpu_regs.z} = {it.operand[7], it.operand == 8'h00};
                outc.result = it.operand;
            end
            OP_STORE: outc.result = src;
            OP_TRANSFER: begin
                case (it.aux)
                    XFER_TAX: val = cpu_regs.a;
                    XFER_TXA: val = cpu_regs.x;
                    XFER_TAY: val = cpu_regs.a;
                    XFER_TYA: val = cpu_regs.y;
                    XFER_TSX: val = cpu_regs.s;
                    default:  val = cpu_regs.x;
                endcase
                case (it.aux)
                    XFER_TAX, XFER_TSX: cpu_regs.x = val;
                    XFER_TXA, XFER_TYA: cpu_regs.a = val;
                    XFER_TAY: cpu_regs.y = val;
                    XFER_TXS: cpu_regs.s = val;
                    default: ;
                endcase
                // TXS leaves the flags alone, and unused kinds do nothing at all.
                if (it.aux <= XFER_TSX) begin
                    {cpu_regs.n, cpu_regs.z} = {val[7], val == 8'h00};
                end
                if (it.aux <= XFER_TXS) outc.result = val;
            end
            OP_FLAGWRITE: begin
                case (it.aux)
                    FLAG_C:  cpu_regs.c = it.bit_value;
                    FLAG_I:  cpu_regs.i = it.bit_value;
                    FLAG_V:  cpu_regs.v = it.bit_value;
                    FLAG_D:  cpu_regs.d = it.bit_value;
                    default: ;
                endcase
            end
            OP_PULLSTATUS: begin
                cpu_regs.s = cpu_regs.s + 8'd1;
                {cpu_regs.n, cpu_regs.v} = it.operand[7:6];
                {cpu_regs.d, cpu_regs.i, cpu_regs.z, cpu_regs.c} = it.operand[3:0];
            end
            OP_PUSHSTATUS: begin
                pushed = 1'b1;
                outc.result = {cpu_regs.n, cpu_regs.v, 1'b1, 1'b1,
                               cpu_regs.d, cpu_regs.i, cpu_regs.z, cpu_regs.c};
                cpu_regs.s = cpu_regs.s - 8'd1;
            end
            OP_BRANCHTEST: begin
                case (it.aux[2:1])
                    BR_CARRY:    flag = cpu_regs.c;
                    BR_ZERO:     flag = cpu_regs.z;
                    BR_OVERFLOW: flag = cpu_regs.v;
                    default:     flag = cpu_regs.n;
                endcase
                outc.branch_taken = it.aux[0] ? flag : ~flag;
            end
            default: ;
        endcase
        outc.status = {cpu_regs.n, cpu_regs.v, 1'b1, pushed,
                       cpu_regs.d, cpu_regs.i, cpu_regs.z, cpu_regs.c};
        return outc;
    endfunction

    // Offers one item and waits until the unit takes it. The sender may idle
    // first; valid is then held with a stable payload until the handshake.
    // The outcome is predicted at the moment of acceptance, since the unit
    // executes items strictly in the order it accepts them.
    task automatic issue(input logic [4:0] op, input logic [1:0] sel,
                         input logic [7:0] opnd, input logic [2:0] aux,
                         input logic bv);
        item_t it;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        it = '{op: op, reg_sel: sel, operand: opnd, aux: aux, bit_value: bv};
        s_valid     <= 1'b1;
        s_op        <= op;
        s_reg_sel   <= sel;
        s_operand   <= opnd;
        s_aux       <= aux;
        s_bit_value <= bv;
        do @(posedge aclk); while (!s_ready);
        expected_outcomes.push_back(execute_op(it));
        items_sent++;
    endtask

    // A random item. A few items carry unused op codes, and operands lean
    // toward the byte values where carry, overflow and sign change.
    function automatic item_t random_item();
        item_t it;
        if ($urandom_range(99) < 6) it.op = 5'($urandom_range(31, 20));
        else it.op = 5'($urandom_range(19));
        it.reg_sel = 2'($urandom_range(3));
        case ($urandom_range(9))
            0:       it.operand = 8'h00;
            1:       it.operand = 8'hFF;
            2:       it.operand = 8'h80;
            3:       it.operand = 8'h7F;
            default: it.operand = 8'($urandom_range(255));
        endcase
        it.aux = 3'($urandom_range(7));
        it.bit_value = 1'($urandom_range(1));
        return it;
    endfunction

    // Arithmetic and logic at the edges: signed overflow, carry out, the
    // borrow of SBC, BIT taking N and V from the operand, and a compare of
    // the memory operand against itself.
    task automatic test_alu_edges();
        issue(OP_LOAD, SEL_A,   8'h7F, AUX_NONE, 1'b0);
        issue(OP_ADC,  SEL_X,   8'h01, AUX_NONE, 1'b0);
        issue(OP_ADC,  SEL_A,   8'hFF, AUX_NONE, 1'b0);
        issue(OP_SBC,  SEL_Y,   8'h00, AUX_NONE, 1'b0);
        issue(OP_AND,  SEL_A,   8'hFF, AUX_NONE, 1'b0);
        issue(OP_ORA,  SEL_MEM, 8'h00, AUX_NONE, 1'b0);
        issue(OP_EOR,  SEL_A,   8'hFF, AUX_NONE, 1'b0);
        issue(OP_BIT,  SEL_A,   8'hC0, AUX_NONE, 1'b0);
        issue(OP_CMP,  SEL_MEM, 8'h80, AUX_NONE, 1'b0);
    endtask

    // Read-modify-write on registers and on the memory byte, stores, and the
    // transfers that touch the stack pointer or do nothing.
    task automatic test_rmw_and_moves();
        issue(OP_LOAD,     SEL_X,   8'h80, AUX_NONE,  1'b0);
        issue(OP_ASL,      SEL_X,   8'h00, AUX_NONE,  1'b0);
        issue(OP_LSR,      SEL_A,   8'h00, AUX_NONE,  1'b0);
        issue(OP_ROL,      SEL_A,   8'h00, AUX_NONE,  1'b0);
        issue(OP_ROR,      SEL_MEM, 8'h01, AUX_NONE,  1'b0);
        issue(OP_DEC,      SEL_MEM, 8'h00, AUX_NONE,  1'b0);
        issue(OP_INC,      SEL_Y,   8'hFF, AUX_NONE,  1'b0);
        issue(OP_STORE,    SEL_MEM, 8'h5A, AUX_NONE,  1'b0);
        issue(OP_TRANSFER, SEL_A,   8'h00, XFER_TSX,  1'b0);
        issue(OP_TRANSFER, SEL_A,   8'h00, XFER_TXS,  1'b0);
        issue(OP_TRANSFER, SEL_A,   8'h00, XFER_NONE, 1'b0);
    endtask

    // Flag writes, including an unused flag index, a pull of every status
    // bit, a push with B set, branch tests, and an op code with no meaning.
    task automatic test_flags_and_status();
        issue(OP_FLAGWRITE,  SEL_A, 8'h00, FLAG_D,                 1'b1);
        issue(OP_FLAGWRITE,  SEL_A, 8'h00, FLAG_NONE,              1'b1);
        issue(OP_PULLSTATUS, SEL_A, 8'hFF, AUX_NONE,               1'b0);
        issue(OP_PUSHSTATUS, SEL_A, 8'h00, AUX_NONE,               1'b0);
        issue(OP_BRANCHTEST, SEL_A, 8'h00, {BR_CARRY, 1'b1},       1'b0);
        issue(OP_BRANCHTEST, SEL_A, 8'h00, {BR_NEGATIVE, 1'b0},    1'b0);
        issue(OP_UNUSED,     SEL_A, 8'hFF, XFER_NONE,              1'b1);
    endtask

    // The result side stops taking items for a long stretch while the sender
    // keeps offering back to back, so the unit fills and must drop s_ready.
    task automatic test_input_stall();
        item_t it;
        int    saved_idle;
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        hold_req_id++;
        repeat (12) begin
            it = random_item();
            issue(it.op, it.reg_sel, it.operand, it.aux, it.bit_value);
        end
        send_idle_pct = saved_idle;
    endtask

    task automatic test_random_traffic(input int count);
        item_t it;
        repeat (count) begin
            it = random_item();
            issue(it.op, it.reg_sel, it.operand, it.aux, it.bit_value);
        end
    endtask

    // Result side: every accepted result is checked against the oldest
    // prediction, then m_ready is chosen for the next edge. A requested
    // hold-off is counted down here at every edge.
    always @(posedge aclk) begin : result_check
        exec_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result: result %02h status %02h branch_taken %0b",
                       m_result, m_status, m_branch_taken);
                fail_count++;
            end else begin
                want = expected_outcomes.pop_front();
                results_checked++;
                if (m_result !== want.result) begin
                    $error("m_result: expected %02h, got %02h", want.result, m_result);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $error("m_status: expected %02h, got %02h", want.status, m_status);
                    fail_count++;
                end
                if (m_branch_taken !== want.branch_taken) begin
                    $error("m_branch_taken: expected %0b, got %0b",
                           want.branch_taken, m_branch_taken);
                    fail_count++;
                end
            end
        end
        if (hold_req_id != hold_done_id) begin
            hold_done_id = hold_req_id;
            hold_cnt = HOLD_LEN;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Main sequence. Reset is held low from the start and released once; the
    // model starts from the documented reset state. The directed tests run
    // with a mostly busy sender and a hesitant receiver, then random traffic
    // runs under three idling mixes before the queue is drained.
    initial begin
        cpu_regs = '{a: 8'h00, x: 8'h00, y: 8'h00, s: 8'hFD,
                     n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 6;
        recv_idle_pct = 56;
        test_alu_edges();
        test_rmw_and_moves();
        test_flags_and_status();
        test_input_stall();
        test_random_traffic(270);

        send_idle_pct = 56;
        recv_idle_pct = 6;
        test_random_traffic(270);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(260);

        // Nothing more to offer; wait for the outstanding results, then keep
        // watching the two-stage pipeline for any stray result.
        s_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);

        $display("Run summary: %0d items sent and %0d results compared (directed edges,",
                 items_sent, results_checked);
        $display("  a long output hold-off, random traffic under three idling mixes).");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of 839 items.
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
